// ----- src/hss_pkg.sv -----
// ----------------------------------------------------------------------------
// hss_pkg: shared types and helpers for the Horspool stream search
// Pattern storage type, the configuration bundle passed from the register
// block to the search sequencer, and the bad-character shift function.
// ----------------------------------------------------------------------------
package hss_pkg;

   localparam int PATTERN_BYTES = 16;
   localparam int LEN_W         = 5;

   typedef logic [PATTERN_BYTES-1:0][7:0] hss_pattern_type;

   typedef struct packed {
      logic [LEN_W-1:0] length;       // clamped pattern length in use
      hss_pattern_type  pattern;      // byte i of the pattern at index i
      logic             length_wr;    // length register written this cycle
      logic [LEN_W-1:0] length_new;   // clamped value being written
   } hss_cfg_type;

   // Rightmost occurrence of b among pattern bytes 0 to len-2 sets the shift;
   // without one the alignment moves by the full pattern length.
   function automatic logic [LEN_W-1:0] bad_char_shift(
      input logic [7:0]       b,
      input logic [LEN_W-1:0] len,
      input hss_pattern_type  pat
   );
      logic [LEN_W-1:0] s;
      s = len;
      for (int i = 0; i < PATTERN_BYTES - 1; i++) begin
         if ((LEN_W'(i + 1) < len) && (pat[i] == b)) begin
            s = len - LEN_W'(1) - LEN_W'(i);
         end
      end
      return s;
   endfunction

endpackage

// ----- src/hss_req_if.sv -----
// ----------------------------------------------------------------------------
// hss_req_if: text byte channel
// Valid/ready channel that carries one text byte per word.
// ----------------------------------------------------------------------------
interface hss_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] text_byte;

   modport source (output valid, output text_byte, input ready);
   modport sink   (input valid, input text_byte, output ready);
endinterface

// ----- src/hss_rsp_if.sv -----
// ----------------------------------------------------------------------------
// hss_rsp_if: compared position channel
// Valid/ready channel that carries one compared text position per word.
// ----------------------------------------------------------------------------
interface hss_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] compared_position;
   logic        last_of_alignment;
   logic        full_match;

   modport source (output valid, output compared_position, output last_of_alignment,
                   output full_match, input ready);
   modport sink   (input valid, input compared_position, input last_of_alignment,
                   input full_match, output ready);
endinterface

// ----- src/hss_ram.sv -----
// ----------------------------------------------------------------------------
// hss_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module hss_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/hss_csr.sv -----
// ----------------------------------------------------------------------------
// hss_csr: configuration registers
// APB-style register block holding the pattern length and the sixteen
// pattern bytes. Registers sit at byte offsets 0, 8 and 16.
// ----------------------------------------------------------------------------
module hss_csr #(
   parameter int MAX_PATTERN_LENGTH = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [4:0]          paddr,
   input  logic [63:0]         pwdata,
   output logic [63:0]         prdata,
   output logic                pready,
   output hss_pkg::hss_cfg_type cfg
);
   import hss_pkg::*;

   localparam logic [1:0] REG_LENGTH = 2'd0;
   localparam logic [1:0] REG_LOW    = 2'd1;
   localparam logic [1:0] REG_HIGH   = 2'd2;
   localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_PATTERN_LENGTH);

   logic [LEN_W-1:0] length_ff, length_in;
   logic [63:0]      low_ff, low_in;
   logic [63:0]      high_ff, high_in;
   logic             wr_en;
   logic [1:0]       reg_index;
   logic [LEN_W-1:0] clamped;

   assign wr_en     = psel && penable && pwrite;
   assign reg_index = paddr[4:3];
   assign pready    = 1'b1;

   always_comb begin
      clamped = pwdata[LEN_W-1:0];
      if (clamped == '0) begin
         clamped = LEN_W'(1);
      end else if (clamped > MAX_LEN) begin
         clamped = MAX_LEN;
      end
   end

   always_comb begin
      length_in = length_ff;
      low_in    = low_ff;
      high_in   = high_ff;
      if (wr_en) begin
         case (reg_index)
            REG_LENGTH: length_in = clamped;
            REG_LOW:    low_in    = pwdata;
            REG_HIGH:   high_in   = pwdata;
            default:    ;
         endcase
      end
   end

   always_comb begin
      case (reg_index)
         REG_LENGTH: prdata = {{(64-LEN_W){1'b0}}, length_ff};
         REG_LOW:    prdata = low_ff;
         REG_HIGH:   prdata = high_ff;
         default:    prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff <= LEN_W'(1);
         low_ff    <= '0;
         high_ff   <= '0;
      end else begin
         length_ff <= length_in;
         low_ff    <= low_in;
         high_ff   <= high_in;
      end
   end

   assign cfg.length     = length_ff;
   assign cfg.pattern    = {high_ff, low_ff};
   assign cfg.length_wr  = wr_en && (reg_index == REG_LENGTH);
   assign cfg.length_new = clamped;

endmodule

// ----- src/horspool_stream_search.sv -----
// ----------------------------------------------------------------------------
// horspool_stream_search: Boyer-Moore-Horspool search over a byte stream
//
//   port   | dir | word contents
//   req    | in  | text_byte
//   rsp    | out | compared_position, last_of_alignment, full_match
//   APB    | in  | pattern_length, pattern_low_bytes, pattern_high_bytes
//
// A byte that does not end the current alignment leaves the block ready.
// A byte that ends it holds req off through a read and a compare state for n
// compared positions (n = 1..16); the single window read port and one byte
// comparator step through them right to left, one per cycle while rsp is free.
// reset is synchronous; the text window itself is not cleared.
// A stalled result word holds the comparator until rsp is ready.
// ----------------------------------------------------------------------------
module horspool_stream_search #(
   parameter int WINDOW_DEPTH       = 32,
   parameter int MAX_PATTERN_LENGTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   hss_req_if.sink     req,
   hss_rsp_if.source   rsp,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [4:0]  paddr,
   input  logic [63:0] pwdata,
   output logic [63:0] prdata,
   output logic        pready
);
   import hss_pkg::*;

   localparam int AW = $clog2(WINDOW_DEPTH);
   localparam logic [AW:0]   DEPTH_W = (AW+1)'(WINDOW_DEPTH);
   localparam logic [AW-1:0] LAST_SLOT = AW'(WINDOW_DEPTH - 1);

   localparam logic [1:0] ST_IDLE    = 2'd0;
   localparam logic [1:0] ST_READ    = 2'd1;
   localparam logic [1:0] ST_COMPARE = 2'd2;

   hss_cfg_type cfg;

   logic [1:0]    state_ff, state_in;
   logic [31:0]   received_ff, received_in;
   logic [31:0]   align_ff, align_in;
   logic [AW-1:0] slot_ff, slot_in;
   logic [AW-1:0] newest_ff, newest_in;
   logic [7:0]    last_byte_ff, last_byte_in;
   logic [3:0]    cnt_ff, cnt_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [31:0]   rsp_pos_ff, rsp_pos_in;
   logic          rsp_last_ff, rsp_last_in;
   logic          rsp_full_ff, rsp_full_in;

   logic          accept;
   logic          out_free;
   logic [7:0]    win_byte;
   logic [AW-1:0] rd_addr;
   logic [AW:0]   back_w;
   logic [LEN_W-1:0] pat_index;
   logic          byte_match;
   logic          at_end;
   logic          done;
   logic [LEN_W-1:0] shift;

   hss_csr #(
      .MAX_PATTERN_LENGTH(MAX_PATTERN_LENGTH)
   ) u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // The read address follows the next count so that the registered read
   // data always belongs to the position held in cnt_ff.
   assign back_w  = {1'b0, newest_ff} - (AW+1)'(cnt_in);
   assign rd_addr = ({1'b0, newest_ff} >= (AW+1)'(cnt_in)) ? back_w[AW-1:0]
                                                         : AW'(back_w + DEPTH_W);

   hss_ram #(
      .WIDTH(8),
      .DEPTH(WINDOW_DEPTH)
   ) u_window (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (slot_ff),
      .wr_data (req.text_byte),
      .rd_addr (rd_addr),
      .rd_data (win_byte)
   );

   assign req.ready  = (state_ff == ST_IDLE);
   assign accept     = req.valid && req.ready;
   assign out_free   = !rsp_valid_ff || rsp.ready;
   assign pat_index  = cfg.length - LEN_W'(1) - LEN_W'(cnt_ff);
   assign byte_match = (win_byte == cfg.pattern[pat_index[3:0]]);
   assign at_end     = ((LEN_W'(cnt_ff) + LEN_W'(1)) == cfg.length);
   assign done       = !byte_match || at_end;
   assign shift      = bad_char_shift(last_byte_ff, cfg.length, cfg.pattern);

   always_comb begin
      state_in     = state_ff;
      received_in  = received_ff;
      align_in     = align_ff;
      slot_in      = slot_ff;
      newest_in    = newest_ff;
      last_byte_in = last_byte_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_pos_in   = rsp_pos_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_full_in  = rsp_full_ff;

      if (cfg.length_wr) begin
         align_in = received_ff + 32'(cfg.length_new) - 32'd1;
      end

      case (state_ff)
         ST_IDLE: begin
            cnt_in = '0;
            if (accept) begin
               received_in  = received_ff + 32'd1;
               newest_in    = slot_ff;
               slot_in      = (slot_ff == LAST_SLOT) ? '0 : slot_ff + AW'(1);
               last_byte_in = req.text_byte;
               if (received_ff == align_ff) begin
                  state_in = ST_READ;
               end
            end
         end
         ST_READ: begin
            state_in = ST_COMPARE;
         end
         ST_COMPARE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_pos_in   = align_ff - 32'(cnt_ff) + 32'd1;
               rsp_last_in  = done;
               rsp_full_in  = byte_match && at_end;
               if (done) begin
                  align_in = align_ff + 32'(shift);
                  state_in = ST_IDLE;
                  cnt_in   = '0;
               end else begin
                  cnt_in = cnt_ff + 4'd1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         received_ff  <= '0;
         align_ff     <= '0;
         slot_ff      <= '0;
         newest_ff    <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         received_ff  <= received_in;
         align_ff     <= align_in;
         slot_ff      <= slot_in;
         newest_ff    <= newest_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      last_byte_ff <= last_byte_in;
      rsp_pos_ff   <= rsp_pos_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_full_ff  <= rsp_full_in;
   end

   assign rsp.valid             = rsp_valid_ff;
   assign rsp.compared_position = rsp_pos_ff;
   assign rsp.last_of_alignment = rsp_last_ff;
   assign rsp.full_match        = rsp_full_ff;

`ifndef NO_ASSERTIONS
   // The compare count never runs past the pattern.
   a_cnt_in_pattern: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_COMPARE) |-> (LEN_W'(cnt_ff) < cfg.length))
      else $error("compare count beyond pattern length");

   // A full match is only ever flagged on the closing word of an alignment.
   a_full_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_full_ff) |-> rsp_last_ff)
      else $error("full match flagged on a non-final word");

   // A byte that does not end the alignment leaves the block ready.
   a_miss_stays_idle: assert property (@(posedge clock) disable iff (reset)
      (accept && (received_ff != align_ff)) |=> (state_ff == ST_IDLE))
      else $error("non-final byte started a compare");

   // Closing an alignment always moves it forward.
   a_align_moves: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_COMPARE && out_free && done) |=>
         (state_ff == ST_IDLE && align_ff != $past(align_ff)))
      else $error("alignment did not advance after closing word");
`endif

endmodule

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench: horspool_stream_search stream check
// Feeds text bytes through the request channel under several pattern
// settings. A predictor of the search works out every compared position for
// each accepted byte, and each result word is checked against the oldest one.
// Both channels stall at random. One long receiver hold-off lets the block fill.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WINDOW        = 32;
   localparam int MAX_LEN       = 16;
   localparam int SETTLE_CYCLES = 24;
   localparam int STALL_LIMIT   = 4000;
   localparam int LONG_HOLD     = 200;
   localparam int REPORT_MAX    = 10;
   localparam int NUM_PHASES    = 10;
   // A negative entry rewrites only the pattern bytes and keeps the alignment.
   localparam int PHASE_LEN [NUM_PHASES] = '{1, 16, 17, 3, 0, 9, 31, -1, 8, 5};

   typedef enum logic [1:0] {
      REG_LENGTH,
      REG_LOW_BYTES,
      REG_HIGH_BYTES,
      REG_UNUSED
   } csr_index_type;

   typedef struct packed {
      logic [31:0] position;
      logic        last_of_alignment;
      logic        full_match;
   } compare_word_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [4:0]  csr_paddr = '0;
   logic [63:0] csr_pwdata = '0;
   logic [63:0] csr_prdata;
   logic        csr_pready;

   hss_req_if text_ch ();
   hss_rsp_if hit_ch ();

   horspool_stream_search dut (
      .clock   (clock),
      .reset   (reset),
      .req     (text_ch),
      .rsp     (hit_ch),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Search state as the predictor sees it.
   logic [7:0]       window_mem [WINDOW];
   logic [31:0]      byte_count = '0;
   logic [31:0]      align_end = '0;
   int unsigned      ring_wr = 0;
   int unsigned      pat_len = 1;
   logic [15:0][7:0] pat = '0;

   compare_word_type compare_q [$];
   logic [7:0]       text_q [$];

   int unsigned bytes_queued = 0;
   int unsigned bytes_taken = 0;
   int unsigned words_checked = 0;
   int unsigned full_hits = 0;
   int unsigned mismatches = 0;
   int unsigned stall_cycles = 0;
   int unsigned send_gap = 0;
   int unsigned hold_left = 0;
   int unsigned stall_left = 0;
   bit          req_fire = 1'b0;
   bit          idle_on = 1'b1;
   bit          long_hold_req = 1'b0;

   // Stores the byte, and if it ends the alignment, compares right to left
   // and queues one word per compared position before moving the alignment.
   task automatic predict_byte(input logic [7:0] b);
      int unsigned      newest;
      int unsigned      matched;
      int unsigned      n;
      int unsigned      shift;
      bit               full;
      logic [31:0]      idx;
      compare_word_type w;
      idx = byte_count;
      newest = ring_wr;
      window_mem[newest] = b;
      ring_wr = (newest + 1) % WINDOW;
      byte_count = idx + 32'd1;
      if (idx == align_end) begin
         matched = 0;
         while (matched < pat_len &&
                window_mem[(newest + WINDOW - matched) % WINDOW] == pat[pat_len - 1 - matched])
            matched++;
         full = (matched == pat_len);
         n = full ? matched : matched + 1;
         for (int j = 0; j < n; j++) begin
            w.position = align_end - 32'(j) + 32'd1;
            w.last_of_alignment = (j == n - 1);
            w.full_match = full && (j == n - 1);
            compare_q.push_back(w);
         end
         shift = pat_len;
         for (int i = 0; i + 1 < pat_len; i++) begin
            if (pat[i] == b) shift = pat_len - 1 - i;
         end
         align_end = align_end + 32'(shift);
      end
   endtask

   task automatic csr_write(input csr_index_type idx, input logic [63:0] value);
      @(negedge clock);
      csr_psel = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite = 1'b1;
      csr_paddr = {idx, 3'b000};
      csr_pwdata = value;
      @(negedge clock);
      csr_penable = 1'b1;
      @(negedge clock);
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      case (idx)
         REG_LENGTH: begin
            if (value[4:0] == 5'd0) pat_len = 1;
            else if (value[4:0] > 5'(MAX_LEN)) pat_len = MAX_LEN;
            else pat_len = 32'(value[4:0]);
            align_end = byte_count + 32'(pat_len) - 32'd1;
         end
         REG_LOW_BYTES:  pat[7:0] = value;
         REG_HIGH_BYTES: pat[15:8] = value;
         default: ;
      endcase
   endtask

   task automatic push_byte(input logic [7:0] b);
      text_q.push_back(b);
      bytes_queued++;
   endtask

   // Text made mostly of pattern copies, damaged copies, suffixes and bytes
   // from the pattern, so that alignments often match part or all of the way.
   task automatic queue_text(input int n);
      int         count;
      int         kind;
      int         span;
      int         flip;
      logic [7:0] b;
      @(posedge clock);
      count = 0;
      while (count < n) begin
         kind = $urandom_range(0, 9);
         span = (kind <= 5) ? pat_len : ((kind == 9) ? $urandom_range(1, pat_len) : 1);
         flip = (kind == 4 || kind == 5) ? $urandom_range(0, pat_len - 1) : -1;
         for (int k = 0; k < span && count < n; k++) begin
            if (kind == 8) b = 8'($urandom_range(0, 255));
            else if (kind == 6 || kind == 7) b = pat[$urandom_range(0, pat_len - 1)];
            else if (kind == 9) b = pat[pat_len - span + k];
            else b = pat[k];
            if (k == flip) b = b ^ 8'($urandom_range(1, 255));
            push_byte(b);
            count++;
         end
      end
   endtask

   function automatic logic [15:0][7:0] make_pattern();
      logic [7:0]       alpha [4];
      logic [15:0][7:0] p;
      foreach (alpha[i]) alpha[i] = 8'($urandom_range(0, 255));
      for (int i = 0; i < 16; i++) begin
         if ($urandom_range(0, 4) == 0) p[i] = 8'($urandom_range(0, 255));
         else p[i] = alpha[$urandom_range(0, 3)];
      end
      return p;
   endfunction

   // Waits at falling edges until every queued byte is taken and every word has come.
   task automatic quiesce(input int extra);
      while (bytes_taken != bytes_queued || compare_q.size() != 0) @(negedge clock);
      repeat (extra) @(negedge clock);
   endtask

   // Byte driver.
   always @(negedge clock) begin
      if (reset) begin
         text_ch.valid <= 1'b0;
         text_ch.text_byte <= 8'h00;
      end else if (!text_ch.valid || req_fire) begin
         if (send_gap > 0) begin
            send_gap--;
            text_ch.valid <= 1'b0;
         end else if (text_q.size() != 0) begin
            text_ch.valid <= 1'b1;
            text_ch.text_byte <= text_q.pop_front();
            if (idle_on && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 9);
         end else begin
            text_ch.valid <= 1'b0;
         end
      end
   end

   // Result receiver: random stall bursts plus one long hold-off on request.
   always @(negedge clock) begin
      if (long_hold_req) begin
         long_hold_req = 1'b0;
         hold_left = LONG_HOLD;
      end
      if (reset) begin
         hit_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         hit_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         hit_ch.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
         stall_left = $urandom_range(1, 9) - 1;
         hit_ch.ready <= 1'b0;
      end else begin
         hit_ch.ready <= 1'b1;
      end
   end

   // Monitor: predicts on accepted bytes, checks accepted words, watches progress.
   always @(posedge clock) begin
      compare_word_type got;
      compare_word_type want;
      bit               word_fire;
      if (reset) begin
         req_fire = 1'b0;
         stall_cycles = 0;
      end else begin
         req_fire = text_ch.valid && text_ch.ready;
         word_fire = hit_ch.valid && hit_ch.ready;
         if (req_fire) begin
            predict_byte(text_ch.text_byte);
            bytes_taken++;
         end
         if (word_fire) begin
            got = '{hit_ch.compared_position, hit_ch.last_of_alignment, hit_ch.full_match};
            words_checked++;
            if (got.last_of_alignment && got.full_match) full_hits++;
            if (compare_q.size() == 0) begin
               mismatches++;
               if (mismatches <= REPORT_MAX)
                  $display("unexpected word: position %0d last %0b full %0b",
                           got.position, got.last_of_alignment, got.full_match);
            end else begin
               want = compare_q.pop_front();
               if (got !== want) begin
                  mismatches++;
                  if (mismatches <= REPORT_MAX)
                     $display("mismatch: expected position %0d last %0b full %0b, got %0d %0b %0b",
                              want.position, want.last_of_alignment, want.full_match,
                              got.position, got.last_of_alignment, got.full_match);
               end
            end
         end
         if (req_fire || word_fire || (csr_psel && csr_penable && csr_pwrite))
            stall_cycles = 0;
         else
            stall_cycles++;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("watchdog: no progress for %0d cycles", stall_cycles);
            $display("testbench: errors");
            $finish;
         end
      end
   end

   initial begin
      logic [15:0][7:0] p;
      int               items;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Reset settings: one zero byte, so a zero matches and all ones does not.
      @(posedge clock);
      push_byte(8'h00);
      push_byte(8'hFF);
      quiesce(SETTLE_CYCLES);

      // A zero length acts as one.
      csr_write(REG_LOW_BYTES, 64'hFF);
      csr_write(REG_LENGTH, 64'd0);
      @(posedge clock);
      push_byte(8'hFF);
      push_byte(8'h00);
      quiesce(SETTLE_CYCLES);

      // Length above the maximum acts as sixteen; the spare index is ignored.
      csr_write(REG_LOW_BYTES, 64'hFFFF_FFFF_FFFF_FFFF);
      csr_write(REG_HIGH_BYTES, 64'hFFFF_FFFF_FFFF_FFFF);
      csr_write(REG_UNUSED, 64'h5A5A_A5A5_0F0F_F0F0);
      csr_write(REG_LENGTH, 64'd31);
      @(posedge clock);
      repeat (16) push_byte(8'hFF);
      push_byte(8'h00);
      quiesce(SETTLE_CYCLES);

      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         p = make_pattern();
         csr_write(REG_LOW_BYTES, p[7:0]);
         csr_write(REG_HIGH_BYTES, p[15:8]);
         if (PHASE_LEN[ph] >= 0) csr_write(REG_LENGTH, 64'(PHASE_LEN[ph]));
         items = (ph == 0) ? 48 : 28;
         queue_text(items / 2);
         // With length one every byte yields a word, so a long hold-off here
         // backs the block up into the byte channel.
         long_hold_req = (ph == 0);
         idle_on = (ph != NUM_PHASES - 1);
         quiesce(0);
         @(posedge clock);
         queue_text(items - items / 2);
         quiesce(SETTLE_CYCLES);
      end

      mismatches += compare_q.size();
      $display("run: %0d text bytes, %0d compared positions checked, %0d full matches",
               bytes_taken, words_checked, full_hits);
      $display("run: lengths 1 to 16 with clamped writes, pattern-only rewrite, long hold-off");
      if (mismatches == 0) begin
         $display("testbench: clean");
      end else begin
         $display("testbench: errors");
      end
      $finish;
   end

endmodule
